FILE: src/tpc_pkg.sv
// Shared constants and types for the triangle properties core.
// Holds the output field layout, the arctangent table and the class codes.
// No dependencies.
package tpc_pkg;

    // Result field widths
    localparam int SIDE_W  = 25;
    localparam int PERIM_W = 27;
    localparam int AREA_W  = 33;
    localparam int ANG_W   = 16;

    // Result tdata layout, lowest bit first
    localparam int OFF_SIDE_A = 0;
    localparam int OFF_SIDE_B = OFF_SIDE_A + SIDE_W;
    localparam int OFF_SIDE_C = OFF_SIDE_B + SIDE_W;
    localparam int OFF_PERIM  = OFF_SIDE_C + SIDE_W;
    localparam int OFF_AREA   = OFF_PERIM + PERIM_W;
    localparam int OFF_ANG_A  = OFF_AREA + AREA_W;
    localparam int OFF_ANG_B  = OFF_ANG_A + ANG_W;
    localparam int OFF_ANG_C  = OFF_ANG_B + ANG_W;
    localparam int OUT_BITS   = OFF_ANG_C + ANG_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Result tuser layout: kind in the low bits, then the degenerate flag
    localparam int OFF_KIND    = 0;
    localparam int OFF_DEGEN   = 2;
    localparam int OUT_TUSER_W = 3;

    // Angle datapath
    localparam int TBL_FRAC    = 30;
    localparam int ATAN_STEPS  = 32;
    localparam int NORM_STAGES = 6;
    localparam int NORM_MSB    = 59;
    localparam int CX_W        = 64;
    localparam int Z_W         = 34;
    localparam logic [Z_W-1:0] PI_Q30 = 34'd3373259426;

    localparam logic [31:0] ATAN_TAB [0:ATAN_STEPS-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Triangle class codes
    typedef enum logic [1:0] {
        KIND_EQUI  = 2'd0,
        KIND_ISO   = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

endpackage

FILE: src/triangle_properties_core.sv
// Triangle properties core: side lengths, perimeter, twice the area, angles, class.
// Depends on tpc_pkg (field layout, arctangent table, class codes).
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------------
//  s_axis   | in  | tvalid/tready         | tdata: x1,y1,x2,y2,x3,y3 (COORD_WIDTH each)
//  m_axis   | out | tvalid/tready         | tdata: sides, perimeter, area, angles
//           |     |                       | tuser: kind, degenerate
//
//  One item per clock when m_axis_tready is high; latency is COORD_WIDTH-independent.
//  The latency is set by the angle path: 6 normalize stages and 32 CORDIC stages;
//  the digit-by-digit square roots (COORD_WIDTH+9 steps) run alongside them.
//  Every stage has a valid bit; a stage loads when it is empty or when the stage
//  after it moves, so bubbles close up and a stall loses or repeats nothing.
//  Reset (rst_n low, asynchronous) empties all stages; payload is not reset.
module triangle_properties_core #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // x1, y1, x2, y2, x3, y3 from the lowest bit up, zero padded
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // side_a, side_b, side_c, perimeter_len, double_area, angle_a, angle_b,
    // angle_c from the lowest bit up, zero padded
    output logic [tpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind, degenerate from the lowest bit up
    output logic [tpc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import tpc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int PW   = 2 * DW;          // product, cross and dot
    localparam int SQW  = 2 * CW + 1;      // squared length
    localparam int AW   = 2 * CW + 1;      // magnitude of the cross product
    localparam int SQ   = CW + 9;          // square root steps
    localparam int RTW  = CW + 9;          // root bits
    localparam int REMW = RTW + 2;         // root remainder
    localparam int NM   = NORM_STAGES + ATAN_STEPS;
    localparam int ST_P1 = 3 + NM + 1;
    localparam int ST_P2 = ST_P1 + 1;
    localparam int NST  = ST_P2 + 1;
    localparam int SH   = TBL_FRAC - ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0] HALF = Z_W'(1) << (SH - 1);

    typedef struct packed {
        logic signed [DW-1:0] ux, uy, vx, vy, wx, wy;
    } f1_t;

    typedef struct packed {
        logic signed [PW-1:0] uxux, uyuy, vxvx, vyvy, wxwx, wywy;
        logic signed [PW-1:0] uxvx, uyvy, uxwx, uywy, vxwx, vywy, uxvy, uyvx;
    } f2_t;

    typedef struct packed {
        logic [SQW-1:0]       sa, sb, sc;
        logic signed [PW-1:0] cr, d1, d2, d3;
    } f3_t;

    typedef struct packed {
        logic [2:0][SQW-1:0]  sq;
        logic [2:0][REMW-1:0] rem;
        logic [2:0][RTW-1:0]  root;
        logic [2:0][CX_W-1:0] cx;
        logic [2:0][CX_W-1:0] cy;
        logic [2:0][Z_W-1:0]  z;
        logic [2:0]           flip;
        logic                 yzero;
        logic [AW-1:0]        acr;
        kind_t                kind;
        logic                 degen;
    } mn_t;

    typedef struct packed {
        logic [2:0][SIDE_W-1:0] side;
        logic [PERIM_W-1:0]     perim;
        logic [AREA_W-1:0]      area;
        logic [2:0][Z_W-1:0]    ang;
        kind_t                  kind;
        logic                   degen;
    } p1_t;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    f1_t f1_reg, f1_next;
    f2_t f2_reg, f2_next;
    f3_t f3_reg, f3_next;
    mn_t mn_reg [0:NM];
    mn_t mn0_next;
    p1_t p1_reg, p1_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0] out_user_reg, out_user_next;

    // Ready flows back: a stage takes data when empty or when it moves on
    assign rdy[NST] = m_axis_tready;
    for (genvar s = 0; s < NST; s++) begin : g_rdy
        assign rdy[s] = ~vld_reg[s] | rdy[s+1];
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= (s == 0) ? s_axis_tvalid : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Stage 0: edge vectors
    always_comb
    begin
        logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
        x1 = s_axis_tdata[0*CW +: CW];
        y1 = s_axis_tdata[1*CW +: CW];
        x2 = s_axis_tdata[2*CW +: CW];
        y2 = s_axis_tdata[3*CW +: CW];
        x3 = s_axis_tdata[4*CW +: CW];
        y3 = s_axis_tdata[5*CW +: CW];
        f1_next.ux = DW'(x2) - DW'(x1);
        f1_next.uy = DW'(y2) - DW'(y1);
        f1_next.vx = DW'(x3) - DW'(x1);
        f1_next.vy = DW'(y3) - DW'(y1);
        f1_next.wx = DW'(x3) - DW'(x2);
        f1_next.wy = DW'(y3) - DW'(y2);
    end

    // Stage 1: all products
    always_comb
    begin
        f2_next.uxux = PW'(f1_reg.ux) * PW'(f1_reg.ux);
        f2_next.uyuy = PW'(f1_reg.uy) * PW'(f1_reg.uy);
        f2_next.vxvx = PW'(f1_reg.vx) * PW'(f1_reg.vx);
        f2_next.vyvy = PW'(f1_reg.vy) * PW'(f1_reg.vy);
        f2_next.wxwx = PW'(f1_reg.wx) * PW'(f1_reg.wx);
        f2_next.wywy = PW'(f1_reg.wy) * PW'(f1_reg.wy);
        f2_next.uxvx = PW'(f1_reg.ux) * PW'(f1_reg.vx);
        f2_next.uyvy = PW'(f1_reg.uy) * PW'(f1_reg.vy);
        f2_next.uxwx = PW'(f1_reg.ux) * PW'(f1_reg.wx);
        f2_next.uywy = PW'(f1_reg.uy) * PW'(f1_reg.wy);
        f2_next.vxwx = PW'(f1_reg.vx) * PW'(f1_reg.wx);
        f2_next.vywy = PW'(f1_reg.vy) * PW'(f1_reg.wy);
        f2_next.uxvy = PW'(f1_reg.ux) * PW'(f1_reg.vy);
        f2_next.uyvx = PW'(f1_reg.uy) * PW'(f1_reg.vx);
    end

    // Stage 2: squared lengths, cross product and the three dot products
    always_comb
    begin
        logic signed [PW-1:0] ssa, ssb, ssc;
        ssa = f2_reg.wxwx + f2_reg.wywy;
        ssb = f2_reg.vxvx + f2_reg.vyvy;
        ssc = f2_reg.uxux + f2_reg.uyuy;
        f3_next.sa = SQW'(ssa);
        f3_next.sb = SQW'(ssb);
        f3_next.sc = SQW'(ssc);
        f3_next.cr = f2_reg.uxvy - f2_reg.uyvx;
        f3_next.d1 = f2_reg.uxvx + f2_reg.uyvy;
        f3_next.d2 = -(f2_reg.uxwx + f2_reg.uywy);
        f3_next.d3 = f2_reg.vxwx + f2_reg.vywy;
    end

    // Stage 3: class, degenerate flag, magnitudes and start values for the roots
    always_comb
    begin
        logic [SQW:0]         ea, eb, ec;
        logic signed [PW-1:0] dots [3];
        logic signed [PW-1:0] dabs;
        logic signed [PW-1:0] crabs;
        ea = (SQW+1)'(f3_reg.sa);
        eb = (SQW+1)'(f3_reg.sb);
        ec = (SQW+1)'(f3_reg.sc);
        dots[0] = f3_reg.d1;
        dots[1] = f3_reg.d2;
        dots[2] = f3_reg.d3;

        if (ea == eb && eb == ec)
        begin
            mn0_next.kind = KIND_EQUI;
        end
        else if (ea == eb || eb == ec || ea == ec)
        begin
            mn0_next.kind = KIND_ISO;
        end
        else if (ea == eb + ec || eb == ea + ec || ec == ea + eb)
        begin
            mn0_next.kind = KIND_RIGHT;
        end
        else
        begin
            mn0_next.kind = KIND_OTHER;
        end

        mn0_next.degen = (f3_reg.sa == '0) || (f3_reg.sb == '0) || (f3_reg.sc == '0);
        crabs = f3_reg.cr[PW-1] ? -f3_reg.cr : f3_reg.cr;
        mn0_next.acr   = AW'(crabs);
        mn0_next.yzero = (f3_reg.cr == '0);
        mn0_next.sq[0] = f3_reg.sa;
        mn0_next.sq[1] = f3_reg.sb;
        mn0_next.sq[2] = f3_reg.sc;
        // Magnitudes are never negative, so the sign bit extends as zero
        for (int j = 0; j < 3; j++)
        begin
            dabs = dots[j][PW-1] ? -dots[j] : dots[j];
            mn0_next.flip[j] = dots[j][PW-1];
            mn0_next.rem[j]  = '0;
            mn0_next.root[j] = '0;
            mn0_next.cx[j]   = CX_W'(dabs);
            mn0_next.cy[j]   = CX_W'(crabs);
            mn0_next.z[j]    = '0;
        end
    end

    // Front stage registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            f1_reg <= f1_next;
        end
        if (rdy[1])
        begin
            f2_reg <= f2_next;
        end
        if (rdy[2])
        begin
            f3_reg <= f3_next;
        end
        if (rdy[3])
        begin
            mn_reg[0] <= mn0_next;
        end
    end

    // Main stages: a normalize or CORDIC step each, and a root digit in the first SQ
    for (genvar k = 0; k < NM; k++) begin : g_main
        logic [2:0][REMW-1:0] rem_n;
        logic [2:0][RTW-1:0]  root_n;
        logic [2:0][CX_W-1:0] cx_n;
        logic [2:0][CX_W-1:0] cy_n;
        logic [2:0][Z_W-1:0]  z_n;
        mn_t                  nx;

        if (k < SQ) begin : g_sq
            localparam int P = SQ - 1 - k;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                logic [SQW:0]    sqx;
                logic [1:0]      pair;
                logic [REMW+1:0] remx;
                logic [REMW+1:0] trial;
                assign sqx = (SQW+1)'(mn_reg[k].sq[j]);
                if (P >= 8) begin : g_pair
                    assign pair = sqx[2*(P-8)+1 -: 2];
                end else begin : g_nopair
                    assign pair = 2'b00;
                end
                assign remx  = {mn_reg[k].rem[j], pair};
                assign trial = (REMW+2)'({mn_reg[k].root[j], 2'b01});
                // Take the digit when the trial fits under the remainder
                always_comb
                begin
                    if (remx >= trial)
                    begin
                        rem_n[j]  = REMW'(remx - trial);
                        root_n[j] = {mn_reg[k].root[j][RTW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_n[j]  = REMW'(remx);
                        root_n[j] = {mn_reg[k].root[j][RTW-2:0], 1'b0};
                    end
                end
            end
        end else begin : g_sq_hold
            assign rem_n  = mn_reg[k].rem;
            assign root_n = mn_reg[k].root;
        end

        if (k < NORM_STAGES) begin : g_norm
            localparam int SHF = 32 >> k;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                logic [CX_W-1:0] m;
                assign m = mn_reg[k].cx[j] | mn_reg[k].cy[j];
                // Shift up while the top of the pair stays clear
                always_comb
                begin
                    if (m[NORM_MSB -: SHF] == '0)
                    begin
                        cx_n[j] = mn_reg[k].cx[j] << SHF;
                        cy_n[j] = mn_reg[k].cy[j] << SHF;
                    end
                    else
                    begin
                        cx_n[j] = mn_reg[k].cx[j];
                        cy_n[j] = mn_reg[k].cy[j];
                    end
                    z_n[j] = mn_reg[k].z[j];
                end
            end
        end else begin : g_cordic
            localparam int I = k - NORM_STAGES;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                logic [CX_W-1:0] dx;
                logic [CX_W-1:0] dy;
                logic [Z_W-1:0]  tab;
                assign dx  = CX_W'($signed(mn_reg[k].cy[j]) >>> I);
                assign dy  = CX_W'($signed(mn_reg[k].cx[j]) >>> I);
                assign tab = Z_W'(ATAN_TAB[I]);
                // Rotate toward the x axis and track the angle
                always_comb
                begin
                    if (!mn_reg[k].cy[j][CX_W-1])
                    begin
                        cx_n[j] = mn_reg[k].cx[j] + dx;
                        cy_n[j] = mn_reg[k].cy[j] - dy;
                        z_n[j]  = mn_reg[k].z[j] + tab;
                    end
                    else
                    begin
                        cx_n[j] = mn_reg[k].cx[j] - dx;
                        cy_n[j] = mn_reg[k].cy[j] + dy;
                        z_n[j]  = mn_reg[k].z[j] - tab;
                    end
                end
            end
        end

        always_comb
        begin
            nx      = mn_reg[k];
            nx.rem  = rem_n;
            nx.root = root_n;
            nx.cx   = cx_n;
            nx.cy   = cy_n;
            nx.z    = z_n;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[3+k+1])
            begin
                mn_reg[k+1] <= nx;
            end
        end
    end

    // Post stage 1: fold the angles into [0, pi] (zero if degenerate), sum the sides
    always_comb
    begin
        logic [RTW+1:0] psum;
        logic [Z_W-1:0] zc;
        psum = (RTW+2)'(mn_reg[NM].root[0]) + (RTW+2)'(mn_reg[NM].root[1])
             + (RTW+2)'(mn_reg[NM].root[2]);
        p1_next.perim = PERIM_W'(psum);
        p1_next.area  = AREA_W'(mn_reg[NM].acr);
        p1_next.kind  = mn_reg[NM].kind;
        p1_next.degen = mn_reg[NM].degen;
        for (int j = 0; j < 3; j++)
        begin
            p1_next.side[j] = SIDE_W'(mn_reg[NM].root[j]);
            zc = mn_reg[NM].z[j][Z_W-1] ? '0 : mn_reg[NM].z[j];
            if (mn_reg[NM].degen)
            begin
                p1_next.ang[j] = '0;
            end
            else if (mn_reg[NM].yzero)
            begin
                p1_next.ang[j] = mn_reg[NM].flip[j] ? PI_Q30 : '0;
            end
            else
            begin
                p1_next.ang[j] = mn_reg[NM].flip[j] ? PI_Q30 - zc : zc;
            end
        end
    end

    // Post stage 2: round the angles half up and pack the result item
    always_comb
    begin
        logic [2:0][ANG_W-1:0] ang;
        logic [Z_W-1:0]        rnd;
        for (int j = 0; j < 3; j++)
        begin
            rnd    = p1_reg.ang[j] + HALF;
            ang[j] = ANG_W'(rnd >> SH);
        end
        out_data_next = '0;
        out_data_next[OFF_SIDE_A +: SIDE_W]  = p1_reg.side[0];
        out_data_next[OFF_SIDE_B +: SIDE_W]  = p1_reg.side[1];
        out_data_next[OFF_SIDE_C +: SIDE_W]  = p1_reg.side[2];
        out_data_next[OFF_PERIM +: PERIM_W]  = p1_reg.perim;
        out_data_next[OFF_AREA +: AREA_W]    = p1_reg.area;
        out_data_next[OFF_ANG_A +: ANG_W]    = ang[0];
        out_data_next[OFF_ANG_B +: ANG_W]    = ang[1];
        out_data_next[OFF_ANG_C +: ANG_W]    = ang[2];
        out_user_next = '0;
        out_user_next[OFF_KIND +: 2]  = p1_reg.kind;
        out_user_next[OFF_DEGEN]      = p1_reg.degen;
    end

    // Output stages
    always_ff @(posedge clk)
    begin
        if (rdy[ST_P1])
        begin
            p1_reg <= p1_next;
        end
        if (rdy[ST_P2])
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // An empty output stage always opens the input
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output stage is empty");

    // Coincident vertices force all angles to zero
    a_degen_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[OFF_DEGEN]) |->
        (m_axis_tdata[OFF_ANG_A +: ANG_W] == '0 && m_axis_tdata[OFF_ANG_B +: ANG_W] == '0
         && m_axis_tdata[OFF_ANG_C +: ANG_W] == '0))
        else $error("degenerate item with nonzero angle");

    // Coincident vertices span no area
    a_degen_area: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[OFF_DEGEN]) |->
        (m_axis_tdata[OFF_AREA +: AREA_W] == '0))
        else $error("degenerate item with nonzero area");

    // No lattice triangle is equilateral unless all vertices coincide
    a_equi_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[OFF_KIND +: 2] == KIND_EQUI) |->
        m_axis_tuser[OFF_DEGEN])
        else $error("equilateral class on a proper triangle");

endmodule

FILE: bench/triangle_properties_checker.sv
// Checker for the triangle properties core: watches both streams, predicts each result.
// Depends on tpc_pkg for the result layout and class codes.
`timescale 1ns / 1ps
module triangle_properties_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [95:0]                     s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [tpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [tpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output int                              fail_count,
    output int                              pending
);
    import tpc_pkg::*;

    typedef struct packed {
        logic [SIDE_W-1:0]  side_a;
        logic [SIDE_W-1:0]  side_b;
        logic [SIDE_W-1:0]  side_c;
        logic [PERIM_W-1:0] perim;
        logic [AREA_W-1:0]  area;
        logic [ANG_W-1:0]   ang_a;
        logic [ANG_W-1:0]   ang_b;
        logic [ANG_W-1:0]   ang_c;
        kind_t              kind;
        logic               degen;
    } tri_result_t;

    tri_result_t triangle_q[$];

    // floor(sqrt(d2) * 256), digit by digit
    function automatic longint unsigned root_q8(longint unsigned d2);
        longint unsigned rem, root, pair, trial;
        rem = 0;
        root = 0;
        for (int p = 39; p >= 0; p--) begin
            pair = (p >= 8) ? ((d2 >> (2 * (p - 8))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // vectoring CORDIC angle of (x, y), y >= 0, rounded to 14 fraction bits
    function automatic logic [ANG_W-1:0] vertex_angle(longint unsigned y, longint x);
        logic            flip;
        longint unsigned ax, m;
        longint          cx, cy, z, dx, dy;
        int              s;
        flip = x < 0;
        ax = flip ? -x : x;
        z = 0;
        s = 0;
        if (y == 0)
            z = 0;
        else
        begin
            m = (ax > y) ? ax : y;
            while (m < (64'd1 << 59))
            begin
                m = m << 1;
                s++;
            end
            cx = ax << s;
            cy = y << s;
            for (int i = 0; i < ATAN_STEPS; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx += dx;
                    cy -= dy;
                    z += longint'(ATAN_TAB[i]);
                end
                else
                begin
                    cx -= dx;
                    cy += dy;
                    z -= longint'(ATAN_TAB[i]);
                end
            end
            if (z < 0)
                z = 0;
        end
        if (flip)
            z = longint'(PI_Q30) - z;
        return ANG_W'((z + (64'd1 << 15)) >> 16);
    endfunction

    function automatic tri_result_t triangle_props(logic [95:0] d);
        longint          x1, y1, x2, y2, x3, y3, ux, uy, vx, vy, wx, wy, cr;
        longint unsigned sa, sb, sc, acr, la, lb, lc;
        tri_result_t     r;
        x1 = longint'($signed(d[15:0]));
        y1 = longint'($signed(d[31:16]));
        x2 = longint'($signed(d[47:32]));
        y2 = longint'($signed(d[63:48]));
        x3 = longint'($signed(d[79:64]));
        y3 = longint'($signed(d[95:80]));
        ux = x2 - x1; uy = y2 - y1;
        vx = x3 - x1; vy = y3 - y1;
        wx = x3 - x2; wy = y3 - y2;
        sa = wx * wx + wy * wy;
        sb = vx * vx + vy * vy;
        sc = ux * ux + uy * uy;
        cr = ux * vy - uy * vx;
        acr = (cr < 0) ? -cr : cr;
        la = root_q8(sa);
        lb = root_q8(sb);
        lc = root_q8(sc);
        r.side_a = SIDE_W'(la);
        r.side_b = SIDE_W'(lb);
        r.side_c = SIDE_W'(lc);
        r.perim = PERIM_W'(la + lb + lc);
        r.area = AREA_W'(acr);
        r.degen = (sa == 0) || (sb == 0) || (sc == 0);
        r.ang_a = '0;
        r.ang_b = '0;
        r.ang_c = '0;
        if (!r.degen)
        begin
            r.ang_a = vertex_angle(acr, ux * vx + uy * vy);
            r.ang_b = vertex_angle(acr, -ux * wx - uy * wy);
            r.ang_c = vertex_angle(acr, vx * wx + vy * wy);
        end
        if (sa == sb && sb == sc)
            r.kind = KIND_EQUI;
        else if (sa == sb || sb == sc || sa == sc)
            r.kind = KIND_ISO;
        else if (sa == sb + sc || sb == sa + sc || sc == sa + sb)
            r.kind = KIND_RIGHT;
        else
            r.kind = KIND_OTHER;
        return r;
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    assign pending = triangle_q.size();

    // predict on input items, compare on result items
    always @(posedge clk)
    begin
        tri_result_t want;
        if (!rst_n)
            fail_count = fail_count;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                triangle_q.push_back(triangle_props(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (triangle_q.size() == 0)
                begin
                    $error("result item with no triangle pending");
                    fail_count++;
                end
                else
                begin
                    want = triangle_q.pop_front();
                    compare_field("side_a", want.side_a, m_axis_tdata[OFF_SIDE_A +: SIDE_W]);
                    compare_field("side_b", want.side_b, m_axis_tdata[OFF_SIDE_B +: SIDE_W]);
                    compare_field("side_c", want.side_c, m_axis_tdata[OFF_SIDE_C +: SIDE_W]);
                    compare_field("perimeter_len", want.perim,
                                  m_axis_tdata[OFF_PERIM +: PERIM_W]);
                    compare_field("double_area", want.area, m_axis_tdata[OFF_AREA +: AREA_W]);
                    compare_field("angle_a", want.ang_a, m_axis_tdata[OFF_ANG_A +: ANG_W]);
                    compare_field("angle_b", want.ang_b, m_axis_tdata[OFF_ANG_B +: ANG_W]);
                    compare_field("angle_c", want.ang_c, m_axis_tdata[OFF_ANG_C +: ANG_W]);
                    compare_field("kind", want.kind, m_axis_tuser[OFF_KIND +: 2]);
                    compare_field("degenerate", want.degen, m_axis_tuser[OFF_DEGEN]);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

FILE: bench/triangle_properties_core_tb.sv
// Testbench top for the triangle properties core: stimulus, back pressure and verdict.
// Depends on tpc_pkg, triangle_properties_core and triangle_properties_checker.
`timescale 1ns / 1ps
module triangle_properties_core_tb;
    import tpc_pkg::*;

    localparam int RANDOM_ITEMS = 1534;
    localparam int DRAIN_CYCLES = 60;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [95:0]            s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    int                     fail_count;
    int                     pending;
    logic                   quiet_phase;
    logic                   long_hold;

    triangle_properties_core dut (.*);
    triangle_properties_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // pack one triangle, x1 in the lowest bits
    function automatic logic [95:0] pack_tri(int x1, int y1, int x2, int y2, int x3, int y3);
        return {16'(y3), 16'(x3), 16'(y2), 16'(x2), 16'(y1), 16'(x1)};
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(logic [95:0] d);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // random gap between items
    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    function automatic int coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 20)) - 10;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // random triangle, often isosceles, right, collinear or with a repeated vertex
    function automatic logic [95:0] random_tri();
        int x1, y1, dx, dy;
        x1 = coord();
        y1 = coord();
        dx = int'($urandom_range(0, 400)) - 200;
        dy = int'($urandom_range(0, 400)) - 200;
        case ($urandom_range(0, 6))
            0: return pack_tri(x1, y1, x1 + dx, y1 + dy, x1 - dy, y1 + dx);
            1: return pack_tri(x1, y1, x1 + dx, y1 + dy, x1 - dx, y1 + dy);
            2: return pack_tri(x1, y1, x1, y1, coord(), coord());
            3: return pack_tri(x1, y1, x1 + dx, y1 + dy, x1 + 2 * dx, y1 + 2 * dy);
            default: return pack_tri(x1, y1, coord(), coord(), coord(), coord());
        endcase
    endfunction

    // receiver: random stalls, one long hold, none at the end
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge clk);
                long_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("triangle_properties_core_tb failed");
        $finish;
    end

    initial
    begin
        logic [95:0] directed [$];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet_phase = 1'b0;
        long_hold = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // field extremes, every class, coincident and collinear vertices
        directed.push_back(pack_tri(0, 0, 0, 0, 0, 0));
        directed.push_back(pack_tri(-32768, -32768, 32767, 32767, -32768, 32767));
        directed.push_back(pack_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        directed.push_back(pack_tri(32767, 32767, -32768, -32768, 32767, -32768));
        directed.push_back(pack_tri(-32768, -32768, -32768, -32768, 32767, 32767));
        directed.push_back(pack_tri(0, 0, 3, 0, 0, 4));
        directed.push_back(pack_tri(0, 0, 4, 0, 2, 5));
        directed.push_back(pack_tri(0, 0, 5, 1, 2, 7));
        directed.push_back(pack_tri(0, 0, 1, 1, 2, 2));
        directed.push_back(pack_tri(0, 0, 2, 2, 1, 1));
        directed.push_back(pack_tri(-1, -1, -1, -1, -1, -1));
        directed.push_back(pack_tri(5, 5, 5, 5, 6, 9));
        directed.push_back(pack_tri(1, 0, 0, 1, 0, 0));
        directed.push_back(pack_tri(32767, 0, -32768, 0, 0, 1));
        directed.push_back(pack_tri(0, 32767, 0, -32768, 1, 0));
        directed.push_back(pack_tri(-21846, 21845, 10922, -10923, 21845, 5461));
        foreach (directed[i])
            send_item(directed[i]);

        // wait for every result before going on
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        // long receiver hold while items keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 100; i++)
            send_item(random_tri());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 200)
                quiet_phase = 1'b1;
            maybe_gap();
            send_item(random_tri());
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && !m_axis_tvalid)
            $display("triangle_properties_core_tb passed");
        else
            $display("triangle_properties_core_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/tpc_pkg.sv
src/triangle_properties_core.sv
bench/triangle_properties_checker.sv
bench/triangle_properties_core_tb.sv
